// ===== src/svs_pkg.sv =====
package svs_pkg;

  // field widths
  localparam int NOW_W  = 31;
  localparam int CODE_W = 10;
  localparam int MV_W   = 16;
  localparam int PCT_W  = 7;
  localparam int INT_W  = 16;
  localparam int REFC_W = 24;
  localparam int AVG_W  = 23;

  // converter full scale, widest allowed value is 4095
  localparam int ADC_FULL_SCALE_DEF = 1023;
  localparam int FS_W               = 12;

  // shared serial divider and multiplier
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 12;
  localparam int MUL_A_W   = 10;
  localparam int MUL_B_W   = 23;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  localparam logic [PCT_W-1:0]     PCT_MAX = 7'd100;
  localparam logic [DIV_DEN_W-1:0] HUNDRED = 12'd100;
  localparam logic [MV_W-1:0]      MV_MAX  = 16'hFFFF;

  // register reset values
  localparam logic [PCT_W-1:0]  PCT_RST  = 7'd10;
  localparam logic [INT_W-1:0]  INT_RST  = 16'd50;
  localparam logic [REFC_W-1:0] REFC_RST = 24'd1125300;

  // apb port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_PCT  = 2'd0,
    REG_INT  = 2'd1,
    REG_REFC = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PCT_W-1:0]  pct;
    logic [INT_W-1:0]  interval;
    logic [REFC_W-1:0] refc;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_RD,
    ST_UPDATE,
    ST_DIV_AVG,
    ST_SUP,
    ST_DIV_SUP,
    ST_DIV_SEN,
    ST_DONE
  } state_t;

  // clamp a quotient to millivolt range
  function automatic logic [MV_W-1:0] sat_mv(input logic [DIV_NUM_W-1:0] v);
    logic [MV_W-1:0] r;
    r = (|v[DIV_NUM_W-1:MV_W]) ? MV_MAX : v[MV_W-1:0];
    return r;
  endfunction

endpackage

// ===== src/svs_in_if.sv =====
interface svs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [svs_pkg::NOW_W-1:0]  now_ms;
  logic [svs_pkg::CODE_W-1:0] adc_code;

  modport source(output valid, kind, now_ms, adc_code, input ready);
  modport sink(input valid, kind, now_ms, adc_code, output ready);
endinterface

// ===== src/svs_out_if.sv =====
interface svs_out_if;
  logic                     valid;
  logic                     ready;
  logic [svs_pkg::MV_W-1:0] supply_mv;
  logic [svs_pkg::MV_W-1:0] sensor_mv;
  logic                     sample_taken;
  logic                     zero_code;

  modport source(output valid, supply_mv, sensor_mv, sample_taken, zero_code, input ready);
  modport sink(input valid, supply_mv, sensor_mv, sample_taken, zero_code, output ready);
endinterface

// ===== src/svs_cfg_regs.sv =====
module svs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [svs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [svs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [svs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output svs_pkg::cfg_t                  cfg
);

  svs_pkg::cfg_t     cfg_r, cfg_nxt;
  svs_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = svs_pkg::reg_idx_t'(paddr[svs_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        svs_pkg::REG_PCT:  cfg_nxt.pct      = pwdata[svs_pkg::PCT_W-1:0];
        svs_pkg::REG_INT:  cfg_nxt.interval = pwdata[svs_pkg::INT_W-1:0];
        svs_pkg::REG_REFC: cfg_nxt.refc     = pwdata[svs_pkg::REFC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pct      <= svs_pkg::PCT_RST;
      cfg_r.interval <= svs_pkg::INT_RST;
      cfg_r.refc     <= svs_pkg::REFC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // readback
  always_comb begin
    prdata = '0;
    unique case (idx)
      svs_pkg::REG_PCT:  prdata = svs_pkg::APB_DATA_W'(cfg_r.pct);
      svs_pkg::REG_INT:  prdata = svs_pkg::APB_DATA_W'(cfg_r.interval);
      svs_pkg::REG_REFC: prdata = svs_pkg::APB_DATA_W'(cfg_r.refc);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== src/svs_serial_div.sv =====
module svs_serial_div (
  input  logic              clk,
  input  logic              rst_n,
  input  svs_pkg::div_req_t req,
  output svs_pkg::div_rsp_t rsp
);

  localparam int NUM_W = svs_pkg::DIV_NUM_W;
  localparam int DEN_W = svs_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  // one quotient bit per cycle: shift next dividend bit into the remainder
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], fits};
      rem_nxt = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule

// ===== src/svs_core.sv =====
module svs_core #(
  parameter int ADC_FULL_SCALE = svs_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  svs_pkg::cfg_t cfg,
  svs_in_if.sink        in_ch,
  svs_out_if.source     out_ch
);

  svs_pkg::state_t state_r, state_nxt;
  svs_pkg::div_req_t div_req;
  svs_pkg::div_rsp_t div_rsp;

  logic                       kind_r, kind_nxt;
  logic [svs_pkg::NOW_W-1:0]  now_r, now_nxt;
  logic [svs_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [svs_pkg::NOW_W-1:0]  last_r, last_nxt;
  logic [svs_pkg::AVG_W-1:0]  avg_r, avg_nxt;
  logic [svs_pkg::MV_W-1:0]   rd_r, rd_nxt;
  logic [svs_pkg::MV_W-1:0]   supply_r, supply_nxt;
  logic [svs_pkg::MV_W-1:0]   sensor_r, sensor_nxt;
  logic                       taken_r, taken_nxt;
  logic                       zero_r, zero_nxt;

  logic                       ov_r, ov_nxt;
  logic [svs_pkg::MV_W-1:0]   o_sup_r, o_sup_nxt;
  logic [svs_pkg::MV_W-1:0]   o_sen_r, o_sen_nxt;
  logic                       o_tak_r, o_tak_nxt;
  logic                       o_zer_r, o_zer_nxt;

  logic [svs_pkg::PCT_W-1:0]   p_eff;
  logic [svs_pkg::MUL_A_W-1:0] mul_a;
  logic [svs_pkg::MUL_B_W-1:0] mul_b;
  logic [svs_pkg::MUL_P_W-1:0] prod;
  logic [svs_pkg::MV_W-1:0]    q_mv;
  logic                        due;

  svs_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign p_eff = (cfg.pct > svs_pkg::PCT_MAX) ? svs_pkg::PCT_MAX : cfg.pct;
  assign q_mv  = svs_pkg::sat_mv(div_rsp.quot);
  assign due   = ({1'b0, last_r} + (svs_pkg::NOW_W + 1)'(cfg.interval)) < {1'b0, now_r};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      svs_pkg::ST_UPDATE: begin
        if (avg_r == '0) begin
          mul_a = svs_pkg::MUL_A_W'(svs_pkg::PCT_MAX);
          mul_b = svs_pkg::MUL_B_W'(rd_r);
        end else begin
          mul_a = svs_pkg::MUL_A_W'(svs_pkg::PCT_MAX - p_eff);
          mul_b = svs_pkg::MUL_B_W'(avg_r);
        end
      end
      svs_pkg::ST_DIV_AVG: begin
        mul_a = svs_pkg::MUL_A_W'(p_eff);
        mul_b = svs_pkg::MUL_B_W'(rd_r);
      end
      svs_pkg::ST_DIV_SUP: begin
        mul_a = svs_pkg::MUL_A_W'(code_r);
        mul_b = svs_pkg::MUL_B_W'(q_mv);
      end
      default: ;
    endcase
  end

  assign prod = svs_pkg::MUL_P_W'(mul_a) * svs_pkg::MUL_P_W'(mul_b);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    now_nxt    = now_r;
    code_nxt   = code_r;
    last_nxt   = last_r;
    avg_nxt    = avg_r;
    rd_nxt     = rd_r;
    supply_nxt = supply_r;
    sensor_nxt = sensor_r;
    taken_nxt  = taken_r;
    zero_nxt   = zero_r;
    div_req    = '0;
    in_ch.ready = 1'b0;

    unique case (state_r)
      svs_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          kind_nxt   = in_ch.kind;
          now_nxt    = in_ch.now_ms;
          code_nxt   = in_ch.adc_code;
          sensor_nxt = '0;
          taken_nxt  = 1'b0;
          zero_nxt   = 1'b0;
          state_nxt  = in_ch.kind ? svs_pkg::ST_SUP : svs_pkg::ST_CHECK;
        end
      end
      svs_pkg::ST_CHECK: begin
        if (!due) begin
          state_nxt = svs_pkg::ST_SUP;
        end else begin
          taken_nxt = 1'b1;
          last_nxt  = now_r;
          if (code_r == '0) begin
            rd_nxt    = svs_pkg::MV_MAX;
            zero_nxt  = 1'b1;
            state_nxt = svs_pkg::ST_UPDATE;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = svs_pkg::DIV_NUM_W'(cfg.refc);
            div_req.den   = svs_pkg::DIV_DEN_W'(code_r);
            state_nxt     = svs_pkg::ST_DIV_RD;
          end
        end
      end
      svs_pkg::ST_DIV_RD: begin
        if (div_rsp.done) begin
          rd_nxt    = q_mv;
          state_nxt = svs_pkg::ST_UPDATE;
        end
      end
      svs_pkg::ST_UPDATE: begin
        if (avg_r == '0) begin
          // seed the average with the reading while the average is zero
          avg_nxt   = prod[svs_pkg::AVG_W-1:0];
          state_nxt = svs_pkg::ST_SUP;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = prod[svs_pkg::DIV_NUM_W-1:0];
          div_req.den   = svs_pkg::HUNDRED;
          state_nxt     = svs_pkg::ST_DIV_AVG;
        end
      end
      svs_pkg::ST_DIV_AVG: begin
        if (div_rsp.done) begin
          avg_nxt   = svs_pkg::AVG_W'(prod + svs_pkg::MUL_P_W'(div_rsp.quot));
          state_nxt = svs_pkg::ST_SUP;
        end
      end
      svs_pkg::ST_SUP: begin
        div_req.start = 1'b1;
        div_req.num   = svs_pkg::DIV_NUM_W'(avg_r);
        div_req.den   = svs_pkg::HUNDRED;
        state_nxt     = svs_pkg::ST_DIV_SUP;
      end
      svs_pkg::ST_DIV_SUP: begin
        if (div_rsp.done) begin
          supply_nxt = q_mv;
          if (kind_r) begin
            div_req.start = 1'b1;
            div_req.num   = prod[svs_pkg::DIV_NUM_W-1:0];
            div_req.den   = svs_pkg::DIV_DEN_W'(ADC_FULL_SCALE);
            state_nxt     = svs_pkg::ST_DIV_SEN;
          end else begin
            state_nxt = svs_pkg::ST_DONE;
          end
        end
      end
      svs_pkg::ST_DIV_SEN: begin
        if (div_rsp.done) begin
          sensor_nxt = q_mv;
          state_nxt  = svs_pkg::ST_DONE;
        end
      end
      svs_pkg::ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          state_nxt = svs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = svs_pkg::ST_IDLE;
    endcase
  end

  // output register, loaded when the finished beat can move in
  always_comb begin
    ov_nxt    = ov_r;
    o_sup_nxt = o_sup_r;
    o_sen_nxt = o_sen_r;
    o_tak_nxt = o_tak_r;
    o_zer_nxt = o_zer_r;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    if (state_r == svs_pkg::ST_DONE && (!ov_r || out_ch.ready)) begin
      ov_nxt    = 1'b1;
      o_sup_nxt = supply_r;
      o_sen_nxt = sensor_r;
      o_tak_nxt = taken_r;
      o_zer_nxt = zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svs_pkg::ST_IDLE;
      last_r  <= '0;
      avg_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      avg_r   <= avg_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    now_r    <= now_nxt;
    code_r   <= code_nxt;
    rd_r     <= rd_nxt;
    supply_r <= supply_nxt;
    sensor_r <= sensor_nxt;
    taken_r  <= taken_nxt;
    zero_r   <= zero_nxt;
    o_sup_r  <= o_sup_nxt;
    o_sen_r  <= o_sen_nxt;
    o_tak_r  <= o_tak_nxt;
    o_zer_r  <= o_zer_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.supply_mv    = o_sup_r;
  assign out_ch.sensor_mv    = o_sen_r;
  assign out_ch.sample_taken = o_tak_r;
  assign out_ch.zero_code    = o_zer_r;

endmodule

// ===== src/supply_voltage_smoother_unit.sv =====
// Supply voltage smoother.
// Input channel in_ch carries one conversion per beat: kind (0 = internal
// reference, 1 = sensor), a millisecond timestamp and a 10-bit code. Every
// input beat yields exactly one beat on out_ch: smoothed supply in mV, the
// scaled sensor voltage (zero for reference beats), and flags for a used
// reference sample and a zero reference code.
// Registers on the APB port: 0x0 smoothing percent, 0x4 minimum interval in
// ms, 0x8 reference constant. Write them only while the block is idle.
// All divisions go through one bit-serial divider, one quotient bit per cycle;
// each division holds the sequencer until the divider is done. A sensor beat
// takes two divisions, a skipped reference beat one and a used reference beat
// up to three. The next item can be taken in the same cycle that the result
// turns valid; one item is in flight. in_ch.ready is high only between items.
// The result sits in an output register, so the next item is taken while that
// result waits; if out_ch is stalled the block finishes the next item and
// then holds it until the register frees up.
// Synchronous reset clears the average, the last update time and all
// control state; registers return to 10 percent, 50 ms and 1125300.
module supply_voltage_smoother_unit #(
  parameter int ADC_FULL_SCALE = svs_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  svs_in_if.sink                         in_ch,
  svs_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [svs_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [svs_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [svs_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  svs_pkg::cfg_t cfg;

  // configuration registers
  svs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // datapath and sequencer
  svs_core #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== src/svs_checker.sv =====
module svs_prop_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [svs_pkg::MV_W-1:0] supply_mv,
  input logic [svs_pkg::MV_W-1:0] sensor_mv,
  input logic                     sample_taken,
  input logic                     zero_code
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(supply_mv) && $stable(sensor_mv) && $stable(sample_taken) && $stable(zero_code))
    else $error("result payload changed while stalled");

  // a zero code flag only comes with a used reference sample
  a_zero_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_code |-> sample_taken)
    else $error("zero code flagged without sample");

  // a used reference sample carries no sensor voltage
  a_taken_sensor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sample_taken |-> sensor_mv == '0)
    else $error("sensor voltage on a reference beat");

  // one item at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind supply_voltage_smoother_unit svs_prop_checker u_svs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .supply_mv    (out_ch.supply_mv),
  .sensor_mv    (out_ch.sensor_mv),
  .sample_taken (out_ch.sample_taken),
  .zero_code    (out_ch.zero_code)
);

// ===== bench/svs_tb_pkg.sv =====
`timescale 1ns / 100ps

package svs_tb_pkg;

  // conversion kind carried by each input beat
  typedef enum logic {
    KIND_REF    = 1'b0,
    KIND_SENSOR = 1'b1
  } conv_kind_t;

endpackage

// ===== bench/svs_checker.sv =====
`timescale 1ns / 100ps

module svs_checker
  import svs_pkg::*;
  import svs_tb_pkg::*;
#(
  parameter int FULL_SCALE = ADC_FULL_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  svs_in_if                     in_mon,
  svs_out_if                    out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output int                    err_cnt,
  output int                    pending
);

  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned MV_LIMIT  = 65535;

  typedef struct packed {
    logic [MV_W-1:0] supply_mv;
    logic [MV_W-1:0] sensor_mv;
    logic            sample_taken;
    logic            zero_code;
  } mv_result_t;

  // shadow registers and smoother state
  logic [PCT_W-1:0]  pct;
  logic [INT_W-1:0]  min_gap;
  logic [REFC_W-1:0] ref_const;
  logic [NOW_W-1:0]  last_ms;
  logic [AVG_W-1:0]  avg_x100;

  mv_result_t mv_expected[$];

  // one conversion through the smoother, updates the state
  function automatic mv_result_t smooth_step(conv_kind_t k, logic [NOW_W-1:0] now,
                                             logic [CODE_W-1:0] code);
    mv_result_t  r;
    logic [32:0] deadline;
    logic [31:0] rd;
    logic [31:0] p;
    logic [31:0] mix;
    logic [31:0] sup;
    logic [47:0] sen;
    r = '0;
    if (k == KIND_REF) begin
      deadline = 33'(last_ms) + 33'(min_gap);
      if (deadline < 33'(now)) begin
        if (code == '0) begin
          rd = MV_LIMIT;
          r.zero_code = 1'b1;
        end else begin
          rd = 32'(ref_const) / 32'(code);
          if (rd > MV_LIMIT) rd = MV_LIMIT;
        end
        p = (pct > PCT_MAX) ? PCT_SCALE : 32'(pct);
        if (avg_x100 == '0) mix = rd * PCT_SCALE;
        else mix = p * rd + ((PCT_SCALE - p) * 32'(avg_x100)) / PCT_SCALE;
        avg_x100 = mix[AVG_W-1:0];
        last_ms = now;
        r.sample_taken = 1'b1;
      end
    end
    sup = 32'(avg_x100) / PCT_SCALE;
    if (sup > MV_LIMIT) sup = MV_LIMIT;
    r.supply_mv = sup[MV_W-1:0];
    if (k == KIND_SENSOR) begin
      sen = (48'(code) * 48'(sup)) / 48'(FULL_SCALE);
      r.sensor_mv = (sen > 48'(MV_LIMIT)) ? MV_MAX : sen[MV_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  // watch config writes, result beats and input beats
  always @(posedge clk) begin
    mv_result_t want;
    if (!rst_n) begin
      pct       = PCT_RST;
      min_gap   = INT_RST;
      ref_const = REFC_RST;
      last_ms   = '0;
      avg_x100  = '0;
      mv_expected.delete();
      err_cnt   = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_PCT:  pct       = cfg_pwdata[PCT_W-1:0];
          REG_INT:  min_gap   = cfg_pwdata[INT_W-1:0];
          REG_REFC: ref_const = cfg_pwdata[REFC_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (mv_expected.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, supply_mv %0d sensor_mv %0d",
                   $time, out_mon.supply_mv, out_mon.sensor_mv);
          err_cnt++;
        end else begin
          want = mv_expected.pop_front();
          check_field("supply_mv", want.supply_mv, out_mon.supply_mv);
          check_field("sensor_mv", want.sensor_mv, out_mon.sensor_mv);
          check_field("sample_taken", want.sample_taken, out_mon.sample_taken);
          check_field("zero_code", want.zero_code, out_mon.zero_code);
        end
      end
      if (in_mon.valid && in_mon.ready)
        mv_expected.push_back(smooth_step(conv_kind_t'(in_mon.kind), in_mon.now_ms,
                                          in_mon.adc_code));
    end
    pending = mv_expected.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import svs_pkg::*;
  import svs_tb_pkg::*;

  localparam logic [NOW_W-1:0] NOW_MAX = {NOW_W{1'b1}};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int          fail_cnt;
  int          outstanding;
  int          hold_req;
  bit          rush;
  int unsigned t_ms;
  int unsigned cur_gap;

  svs_in_if  in_if ();
  svs_out_if out_if ();

  supply_voltage_smoother_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  svs_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .err_cnt     (fail_cnt),
    .pending     (outstanding)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (rush) return 0;
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return {CODE_W{1'b1}};
    if (r < 15) return CODE_W'($urandom_range(1, 3));
    return CODE_W'($urandom);
  endfunction

  // one beat on the input channel, called and returning at a falling edge
  task automatic offer_conv(conv_kind_t k, logic [NOW_W-1:0] now, logic [CODE_W-1:0] code);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid    = 1'b1;
    in_if.kind     = k;
    in_if.now_ms   = now;
    in_if.adc_code = code;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // apb write: setup then access
  task automatic write_cfg(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // every result back before touching registers
  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // random register setting, upper data bits carry junk
  task automatic pick_cfg();
    logic [PCT_W-1:0]  p;
    logic [INT_W-1:0]  iv;
    logic [REFC_W-1:0] rc;
    int                r;
    r = $urandom_range(0, 9);
    p = (r == 0) ? PCT_W'(0) : (r == 1) ? PCT_MAX : (r == 2) ? {PCT_W{1'b1}} :
        PCT_W'($urandom_range(1, 99));
    r = $urandom_range(0, 9);
    iv = (r == 0) ? INT_W'(0) : (r == 1) ? {INT_W{1'b1}} : (r < 5) ? INT_W'($urandom) :
         INT_W'($urandom_range(1, 200));
    r = $urandom_range(0, 9);
    rc = (r == 0) ? REFC_W'(1) : (r == 1) ? {REFC_W{1'b1}} : (r == 2) ? REFC_W'($urandom) :
         (r == 3) ? REFC_W'($urandom_range(0, 5000)) : REFC_W'($urandom_range(900000, 1400000));
    wait_idle();
    write_cfg(REG_PCT, {(APB_DATA_W - PCT_W)'($urandom), p});
    write_cfg(REG_INT, {(APB_DATA_W - INT_W)'($urandom), iv});
    write_cfg(REG_REFC, {(APB_DATA_W - REFC_W)'($urandom), rc});
    cur_gap = iv;
  endtask

  // mostly reference beats paced around the interval, plus sensors and noise
  task automatic run_mix(int n_items, bit press);
    int          i;
    int          r;
    int unsigned t_send;
    for (i = 0; i < n_items; i++) begin
      if (press && i == 0) begin
        hold_req = 600;
        rush     = 1'b1;
      end
      if (press && i == 40) rush = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        offer_conv(KIND_SENSOR, NOW_W'($urandom), pick_code());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          t_ms += cur_gap + $urandom_range(1, 40);
          t_send = t_ms;
        end else if (r < 70) begin
          t_ms += cur_gap + 1;
          t_send = t_ms;
        end else if (r < 85) begin
          t_ms += $urandom_range(0, cur_gap);
          t_send = t_ms;
        end else if (r < 93) begin
          t_send = (t_ms > 2000) ? t_ms - $urandom_range(1, 2000) : 0;
        end else begin
          t_send = $urandom_range(0, t_ms + 2 * cur_gap);
        end
        offer_conv(KIND_REF, NOW_W'(t_send), pick_code());
      end
    end
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin : sink_drive
    int run_len;
    int stall_len;
    out_if.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        out_if.ready = 1'b0;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
      end
      stall_len = idle_gap();
      if (stall_len > 0) begin
        out_if.ready = 1'b0;
        repeat (stall_len) @(negedge clk);
      end
      out_if.ready = 1'b1;
      run_len = $urandom_range(1, 24);
      repeat (run_len) @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin : stim
    int ph;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_REF;
    in_if.now_ms   = '0;
    in_if.adc_code = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    hold_req       = 0;
    rush           = 1'b0;
    cur_gap        = INT_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: sensor before any sample, interval boundary, zero code,
    // saturated quotient, time running backwards
    offer_conv(KIND_SENSOR, '0, 10'd1023);
    offer_conv(KIND_REF, 31'd50, 10'd1023);
    offer_conv(KIND_REF, 31'd51, 10'd1023);
    offer_conv(KIND_SENSOR, NOW_MAX, 10'd1023);
    offer_conv(KIND_REF, 31'd101, 10'd512);
    offer_conv(KIND_REF, 31'd102, 10'd0);
    offer_conv(KIND_REF, 31'd153, 10'd1);
    offer_conv(KIND_REF, 31'd120, 10'd700);
    offer_conv(KIND_SENSOR, '0, 10'd0);
    offer_conv(KIND_SENSOR, 31'h2AAA_AAAA, 10'h155);

    // no smoothing weight, no interval, widest constant
    wait_idle();
    write_cfg(REG_PCT, 32'd0);
    write_cfg(REG_INT, 32'd0);
    write_cfg(REG_REFC, 32'h00FF_FFFF);
    offer_conv(KIND_REF, 31'd154, 10'd1023);
    offer_conv(KIND_REF, 31'd154, 10'd1023);
    offer_conv(KIND_REF, 31'd155, 10'd255);
    offer_conv(KIND_SENSOR, 31'h5555_5555, 10'h2AA);

    // full weight, longest interval, zero constant drives the average to zero
    wait_idle();
    write_cfg(REG_PCT, 32'd100);
    write_cfg(REG_INT, 32'd65535);
    write_cfg(REG_REFC, 32'd0);
    offer_conv(KIND_REF, 31'd65691, 10'd7);
    offer_conv(KIND_REF, 31'd131227, 10'd3);
    offer_conv(KIND_SENSOR, 31'd0, 10'd1023);

    // percent above 100, average reseeds
    wait_idle();
    write_cfg(REG_PCT, 32'd127);
    write_cfg(REG_REFC, 32'd1125300);
    offer_conv(KIND_REF, 31'd196763, 10'd1023);
    offer_conv(KIND_REF, 31'd262299, 10'd300);
    offer_conv(KIND_SENSOR, 31'd0, 10'd300);

    // random phases, one with a long result hold, one with no idling
    t_ms    = 300000;
    cur_gap = 65535;
    for (ph = 0; ph < 8; ph++) begin
      pick_cfg();
      if (ph == 5) rush = 1'b1;
      run_mix(200, ph == 2);
      rush = 1'b0;
    end

    // timestamps at the top of the range
    wait_idle();
    write_cfg(REG_INT, 32'd65535);
    offer_conv(KIND_REF, NOW_MAX - 31'd65536, 10'd1023);
    offer_conv(KIND_REF, NOW_MAX, 10'd600);
    offer_conv(KIND_REF, NOW_MAX, 10'd600);
    offer_conv(KIND_SENSOR, NOW_MAX, 10'h3FF);
    offer_conv(KIND_REF, 31'd5, 10'd600);

    wait_idle();
    repeat (150) @(negedge clk);
    if (fail_cnt == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #25_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
